// ===== rtl/sai_pkg.sv =====
// Types and codes shared by the sorted array insert/delete block.
package sai_pkg;

   localparam int ACTION_BITS = 2;
   localparam int ITEM_BITS   = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [ITEM_BITS-1:0]   item_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   found;
      logic [COUNT_BITS-1:0]  match_count;
      logic [COUNT_BITS-1:0]  fill_count;
   } rsp_type;

endpackage

// ===== rtl/sai_ram.sv =====
// Single-port-write, registered-read memory holding the sorted entries.
module sai_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sorted_array_insert_delete.sv =====
// Sorted multiset store: scan, insert with tail shift, delete all copies, query.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data  (req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (rsp_type)
//
// One transfer at a time. Scan reads entries in turn up to the first larger entry; an
// insert shift or delete compaction reads and writes each moved entry in turn through
// the single read and write port of the entry memory, followed by scan end, decode,
// last step, result and idle. Synchronous reset empties the array.
// A waiting result does not block the next request; a new result waits for rsp_ready.
module sorted_array_insert_delete
   import sai_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN_RD  = 4'd1;
   localparam logic [3:0] ST_SCAN_CHK = 4'd2;
   localparam logic [3:0] ST_EXEC     = 4'd3;
   localparam logic [3:0] ST_INS_RD   = 4'd4;
   localparam logic [3:0] ST_INS_WR   = 4'd5;
   localparam logic [3:0] ST_DEL_RD   = 4'd6;
   localparam logic [3:0] ST_DEL_WR   = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [CW-1:0]          copies_ff, copies_in;
   logic [CW-1:0]          above_ff, above_in;
   logic [ACTION_BITS-1:0] act_ff, act_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_BITS-1:0]  mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_BITS-1:0]  mem_rdata;

   logic [CW-1:0]                  idx_dec;
   logic [CW-1:0]                  del_src;
   logic [VALUE_BITS+ITEM_BITS-1:0] item_ext;
   logic [CW+COUNT_BITS-1:0]       copies_ext;
   logic [CW+COUNT_BITS-1:0]       used_ext;

   sai_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign idx_dec    = idx_ff - 1'b1;
   assign del_src    = idx_ff + copies_ff;
   assign item_ext   = {{VALUE_BITS{1'b0}}, req_data.item_value};
   assign copies_ext = {{COUNT_BITS{1'b0}}, copies_ff};
   assign used_ext   = {{COUNT_BITS{1'b0}}, used_ff};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      copies_in    = copies_ff;
      above_in     = above_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_wdata    = mem_rdata;
      mem_raddr    = idx_ff[AW-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_data.action;
               val_in    = item_ext[VALUE_BITS-1:0];
               idx_in    = '0;
               copies_in = '0;
               status_in = STAT_OK;
               state_in  = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == used_ff) begin
               above_in = idx_ff;
               state_in = ST_EXEC;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (mem_rdata == val_ff) begin
               copies_in = copies_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
               state_in  = ST_SCAN_RD;
            end else if (mem_rdata > val_ff) begin
               above_in = idx_ff;
               state_in = ST_EXEC;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_INSERT: begin
                  if (used_ff == CAP_CNT) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     idx_in   = used_ff;
                     state_in = ST_INS_RD;
                  end
               end
               ACT_DELETE: begin
                  if (copies_ff == '0) begin
                     status_in = STAT_NOT_FOUND;
                     state_in  = ST_DONE;
                  end else begin
                     idx_in   = above_ff - copies_ff;
                     state_in = ST_DEL_RD;
                  end
               end
               default: begin
                  status_in = (copies_ff == '0) ? STAT_NOT_FOUND : STAT_OK;
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_INS_RD: begin
            if (idx_ff == above_ff) begin
               mem_we    = 1'b1;
               mem_waddr = above_ff[AW-1:0];
               mem_wdata = val_ff;
               used_in   = used_ff + 1'b1;
               state_in  = ST_DONE;
            end else begin
               mem_raddr = idx_dec[AW-1:0];
               state_in  = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = ST_INS_RD;
         end
         ST_DEL_RD: begin
            if (del_src == used_ff) begin
               used_in  = used_ff - copies_ff;
               state_in = ST_DONE;
            end else begin
               mem_raddr = del_src[AW-1:0];
               state_in  = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_DEL_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.found       = (copies_ff != '0);
               rsp_data_in.match_count = copies_ext[COUNT_BITS-1:0];
               rsp_data_in.fill_count  = used_ext[COUNT_BITS-1:0];
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      copies_ff   <= copies_in;
      above_ff    <= above_in;
      act_ff      <= act_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
